FILE: sv/assert_macros.svh
// Assertion macros for the cosine similarity RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: sv/cos_sim_pkg.sv
// Package for the cosine similarity stream block: widths, status codes and
// the controller/datapath command and status structs. Depends on nothing.
package cos_sim_pkg;
   localparam int ElemBits  = 16;
   localparam int MaxLen    = 4096;
   localparam int CountBits = 13;
   localparam int DotBits   = 45;
   localparam int NormBits  = 43;
   localparam int RootBits  = 22;
   localparam int DenBits   = 44;
   localparam int NumBits   = 60;
   localparam int QuotBits  = 16;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusZeroNorm = 2'd1;
   localparam logic [1:0] StatusTooLong  = 2'd2;

   typedef struct packed {
      logic accumulate;
      logic start_root;
      logic start_mul;
      logic start_div;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic too_long;
      logic zero_norm;
      logic root_done;
      logic div_done;
   } stat_type;
endpackage

FILE: sv/cos_sim_datapath.sv
// Datapath of the cosine similarity block: accumulators, two shared-cycle
// square root iterators, a denominator multiply and a restoring divider.
// Depends on cos_sim_pkg.
module cos_sim_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  cos_sim_pkg::cmd_type  cmd,
   output cos_sim_pkg::stat_type stat,
   input  logic signed [15:0]    a_elem,
   input  logic signed [15:0]    b_elem,
   output logic signed [15:0]    similarity
);
   logic signed [cos_sim_pkg::DotBits-1:0] dot_ff, dot_in;
   logic [cos_sim_pkg::NormBits-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [cos_sim_pkg::CountBits-1:0] cnt_ff, cnt_in;
   logic ovf_ff, ovf_in;
   logic signed [31:0] pab, paa, pbb;

   // root iterators: operand, result, step count
   logic [cos_sim_pkg::NormBits:0] ra_x_ff, rb_x_ff;
   logic [cos_sim_pkg::RootBits-1:0] ra_ff, rb_ff;
   logic [4:0] rstep_ff;
   logic rbusy_ff;
   logic [cos_sim_pkg::DenBits-1:0] den_ff;

   logic neg_ff;
   logic [cos_sim_pkg::NumBits-1:0] num_ff;
   logic [cos_sim_pkg::DenBits:0] rem_ff;
   logic [cos_sim_pkg::NumBits-1:0] quo_ff;
   logic [5:0] dstep_ff;
   logic dbusy_ff;

   assign pab = a_elem * b_elem;
   assign paa = a_elem * a_elem;
   assign pbb = b_elem * b_elem;

   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cmd.clear) begin
         dot_in = '0;
         na_in  = '0;
         nb_in  = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.accumulate) begin
         if (cnt_ff >= cos_sim_pkg::CountBits'(cos_sim_pkg::MaxLen)) begin
            ovf_in = 1'b1;
         end else begin
            dot_in = dot_ff + cos_sim_pkg::DotBits'(pab);
            na_in  = na_ff + cos_sim_pkg::NormBits'($unsigned(paa));
            nb_in  = nb_ff + cos_sim_pkg::NormBits'($unsigned(pbb));
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // one root bit per cycle, from bit 21 down: keep it if its square still fits
   function automatic logic [cos_sim_pkg::RootBits-1:0] root_step(
      input logic [cos_sim_pkg::NormBits:0] x,
      input logic [cos_sim_pkg::RootBits-1:0] r,
      input logic [4:0] s
   );
      logic [cos_sim_pkg::RootBits-1:0] rt;
      logic [cos_sim_pkg::NormBits:0] trial;
      rt = r | (cos_sim_pkg::RootBits'(1) << (5'd21 - s));
      trial = {22'd0, rt} * {22'd0, rt};
      if (trial <= x) return rt;
      return r;
   endfunction

   logic [cos_sim_pkg::RootBits-1:0] sa, sb;
   assign sa = root_step(ra_x_ff, ra_ff, rstep_ff);
   assign sb = root_step(rb_x_ff, rb_ff, rstep_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= '0;
         na_ff    <= '0;
         nb_ff    <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         rbusy_ff <= 1'b0;
         rstep_ff <= '0;
         dbusy_ff <= 1'b0;
      end else begin
         dot_ff <= dot_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
         if (cmd.start_root) begin
            ra_x_ff  <= {1'b0, na_ff};
            rb_x_ff  <= {1'b0, nb_ff};
            ra_ff    <= '0;
            rb_ff    <= '0;
            rstep_ff <= '0;
            rbusy_ff <= 1'b1;
         end else if (rbusy_ff) begin
            ra_ff <= sa;
            rb_ff <= sb;
            if (rstep_ff == 5'd21) rbusy_ff <= 1'b0;
            else rstep_ff <= rstep_ff + 1'b1;
         end
         if (cmd.start_mul) den_ff <= {22'd0, ra_ff} * {22'd0, rb_ff};
         if (cmd.start_div) begin
            neg_ff <= dot_ff[cos_sim_pkg::DotBits-1];
            num_ff <= {(dot_ff[cos_sim_pkg::DotBits-1] ? -dot_ff : dot_ff), 15'd0};
            rem_ff <= '0;
            quo_ff <= '0;
            dstep_ff <= '0;
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            logic [cos_sim_pkg::DenBits+1:0] t;
            t = {rem_ff, num_ff[cos_sim_pkg::NumBits-1]};
            num_ff <= num_ff << 1;
            if (t >= {2'b0, den_ff}) begin
               rem_ff <= (cos_sim_pkg::DenBits+1)'(t - {2'b0, den_ff});
               quo_ff <= {quo_ff[cos_sim_pkg::NumBits-2:0], 1'b1};
            end else begin
               rem_ff <= t[cos_sim_pkg::DenBits:0];
               quo_ff <= {quo_ff[cos_sim_pkg::NumBits-2:0], 1'b0};
            end
            if (dstep_ff == 6'(cos_sim_pkg::NumBits-1)) dbusy_ff <= 1'b0;
            else dstep_ff <= dstep_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (neg_ff) similarity = (quo_ff >= 60'd32768) ? 16'sh8000 : -$signed(quo_ff[15:0]);
      else similarity = (quo_ff >= 60'd32767) ? 16'sh7fff : $signed(quo_ff[15:0]);
   end

   assign stat.too_long  = ovf_ff;
   assign stat.zero_norm = (na_ff == '0) || (nb_ff == '0);
   assign stat.root_done = !rbusy_ff && !cmd.start_root;
   assign stat.div_done  = !dbusy_ff && !cmd.start_div;
endmodule

FILE: sv/cos_sim_ctrl.sv
// Controller of the cosine similarity block: sequences accumulate, root,
// multiply, divide and result delivery. Depends on cos_sim_pkg.
`include "assert_macros.svh"
module cos_sim_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_status,
   output logic                  load_sim,
   output cos_sim_pkg::cmd_type  cmd,
   input  cos_sim_pkg::stat_type stat
);
   typedef enum logic [2:0] {Accum, Check, Root, Mul, Divide, Hold} state_type;
   state_type state_ff;
   logic [1:0] status_ff;
   logic rvalid_ff;
   logic take;
   logic out_free;
   logic rsp_set;
   logic [1:0] rsp_code;

   assign req_tready = (state_ff == Accum);
   assign take = req_tvalid && req_tready;
   assign out_free = !rvalid_ff || rsp_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_status = status_ff;

   always_comb begin
      cmd = '0;
      load_sim = 1'b0;
      rsp_set = 1'b0;
      rsp_code = cos_sim_pkg::StatusOk;
      cmd.accumulate = take;
      unique case (state_ff)
         Check: if (stat.too_long || stat.zero_norm) begin
            // hold the sums until the output register is free
            if (out_free) begin
               cmd.clear = 1'b1;
               rsp_set = 1'b1;
               rsp_code = stat.too_long ? cos_sim_pkg::StatusTooLong
                                        : cos_sim_pkg::StatusZeroNorm;
            end
         end else cmd.start_root = 1'b1;
         Mul: cmd.start_mul = 1'b1;
         Hold: cmd.start_div = 1'b1;
         Divide: if (stat.div_done && out_free) begin
            cmd.clear = 1'b1;
            load_sim = 1'b1;
            rsp_set = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= Accum;
         rvalid_ff <= 1'b0;
         status_ff <= cos_sim_pkg::StatusOk;
      end else begin
         if (rsp_set) begin
            rvalid_ff <= 1'b1;
            status_ff <= rsp_code;
         end else if (rsp_tready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            Accum: if (take && req_tlast) state_ff <= Check;
            Check: begin
               if (rsp_set) state_ff <= Accum;
               else if (!stat.too_long && !stat.zero_norm) state_ff <= Root;
            end
            Root: if (stat.root_done) state_ff <= Mul;
            Mul: state_ff <= Hold;
            Hold: state_ff <= Divide;
            Divide: if (rsp_set) state_ff <= Accum;
            default: state_ff <= Accum;
         endcase
      end
   end

   `ASSERT_CLK(no_take_busy, clock, reset, take |-> state_ff == Accum, "request taken while busy")
   `ASSERT_CLK(rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `ASSERT_CLK(status_holds, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_status), "status changed while waiting")
endmodule

FILE: sv/cosine_similarity_stream.sv
// Cosine similarity stream: one element pair per cycle is accumulated while
// req_tready is high; on the last pair the block runs a 22-step square root on
// both norms, one multiply and a 60-step restoring divide. The result is
// registered once the divide is done and the output is free; requests are then
// taken again. Zero norm and too-long results come from the check state; a
// waiting result stalls only the next tail. Synchronous active-high reset.
module cosine_similarity_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // a_elem[15:0], b_elem[31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // similarity[15:0]
   output logic [1:0]  rsp_tuser   // status[1:0]
);
   cos_sim_pkg::cmd_type  cmd;
   cos_sim_pkg::stat_type stat;
   logic load_sim;
   logic signed [15:0] sim;
   logic [15:0] sim_ff;
   logic [1:0] status;

   always_ff @(posedge clock) begin
      if (load_sim) sim_ff <= sim;
      else if (cmd.clear) sim_ff <= '0;
   end

   cos_sim_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_status(status), .load_sim, .cmd, .stat
   );

   cos_sim_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .a_elem(req_tdata[15:0]), .b_elem(req_tdata[31:16]), .similarity(sim)
   );

   assign rsp_tdata = sim_ff;
   assign rsp_tuser = status;
endmodule
